FILE: rtl/stbs_pkg.sv
// Shared types, constants and helpers for the sorted table binary search block.
package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = ADDR_W + 1;

    // Fixed field widths
    localparam int KEY_W   = 32;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 8;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [POS_W-1:0]        entry_position;
        logic signed [KEY_W-1:0] key_value;
    } in_beat_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
    } out_beat_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic probe_first;
        logic step;
        logic set_found;
        logic set_miss;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic range_open;
        logic next_open;
        logic hit;
    } dp_status_t;

    // Midpoint of [lo, hi_excl - 1], rounded down; valid only when lo < hi_excl
    function automatic logic [ADDR_W-1:0] mid_of(input logic [BOUND_W-1:0] lo,
                                                 input logic [BOUND_W-1:0] hi_excl);
        logic [BOUND_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi_excl} - (BOUND_W+1)'(1);
        return sum[ADDR_W:1];
    endfunction

endpackage

FILE: rtl/stbs_datapath.sv
// Datapath: key table memory, search bounds, probe compare and result registers.
module stbs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [7:0]          cfg_write_data,
    input  stbs_pkg::in_beat_t  in_data,
    input  stbs_pkg::dp_cmd_t   cmd,
    output stbs_pkg::dp_status_t status,
    output stbs_pkg::out_beat_t out_data
);
    import stbs_pkg::*;

    logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]        rd_data_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [BOUND_W-1:0]      low_reg, low_next;
    logic [BOUND_W-1:0]      hi_reg, hi_next;
    logic [ADDR_W-1:0]       mid_reg, mid_next;
    logic [ADDR_W-1:0]       cur_mid, step_mid, rd_addr;
    logic                    key_less;
    out_beat_t               res_reg;
    out_beat_t               out_data_reg;

    // Entry count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            count_reg <= cfg_write_data;
        end
    end

    // Probe compare and next bounds
    assign cur_mid  = mid_of(low_reg, hi_reg);
    assign key_less = $signed(rd_data_reg) < key_reg;

    always_comb
    begin
        if (key_less)
        begin
            low_next = BOUND_W'(mid_reg) + BOUND_W'(1);
            hi_next  = hi_reg;
        end
        else
        begin
            low_next = low_reg;
            hi_next  = BOUND_W'(mid_reg);
        end
    end

    assign step_mid = mid_of(low_next, hi_next);
    assign rd_addr  = cmd.probe_first ? cur_mid : step_mid;
    assign mid_next = rd_addr;

    assign status.range_open = low_reg < hi_reg;
    assign status.next_open  = low_next < hi_next;
    assign status.hit        = $signed(rd_data_reg) == key_reg;

    // Key table: one write port for loads, one registered read port for probes
    always_ff @(posedge clk)
    begin
        if (cmd.load && (32'(in_data.entry_position) < TABLE_DEPTH))
        begin
            key_mem[ADDR_W'(in_data.entry_position)] <= in_data.key_value;
        end
        if (cmd.probe_first || cmd.step)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    // Search bounds and sought key
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= in_data.key_value;
            low_reg <= '0;
            if (32'(count_reg) > TABLE_DEPTH)
            begin
                hi_reg <= BOUND_W'(TABLE_DEPTH);
            end
            else
            begin
                hi_reg <= BOUND_W'(count_reg);
            end
        end
        else if (cmd.step)
        begin
            low_reg <= low_next;
            hi_reg  <= hi_next;
        end
        if (cmd.probe_first || cmd.step)
        begin
            mid_reg <= mid_next;
        end
    end

    // Result and output beat registers
    always_ff @(posedge clk)
    begin
        if (cmd.set_found)
        begin
            res_reg.found          <= 1'b1;
            res_reg.match_position <= POS_W'(mid_reg);
        end
        else if (cmd.set_miss)
        begin
            res_reg.found          <= 1'b0;
            res_reg.match_position <= '0;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_data = out_data_reg;

endmodule

FILE: rtl/stbs_ctrl.sv
// Controller: search sequencing and input/output handshake.
module stbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 in_command,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  stbs_pkg::dp_status_t status,
    output stbs_pkg::dp_cmd_t    cmd
);
    import stbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADDR = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_beat;

    assign in_stall = (state_reg != S_IDLE);
    assign in_beat  = in_valid && !in_stall;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    if (in_command == CMD_SEARCH)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_ADDR;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_ADDR:
            begin
                if (status.range_open)
                begin
                    cmd.probe_first = 1'b1;
                    state_next      = S_CMP;
                end
                else
                begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_CMP:
            begin
                if (status.hit)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_DONE;
                end
                else if (status.next_open)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for a free output slot
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: drops when the beat is taken, set on a new result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid / in_stall   | command, entry_position, key_value
//  out     | output    | out_valid / out_stall | found, match_position
//  cfg     | input     | cfg_write_en          | entry_count (cfg_write_data)
//
// A load beat is written when accepted and leaves the controller idle. A search beat
// probes the table (at most 8 probes for 128 entries): one per cycle, set by the
// single registered read port of the key table. Reset clears the controller and
// entry_count; table contents are undefined until loaded. A finished result waits
// in the output register under out_stall while the next beat is accepted.
module sorted_table_binary_search (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [7:0]          cfg_write_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  stbs_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output stbs_pkg::out_beat_t out_data
);
    import stbs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    stbs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_command (in_data.command),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .cmd        (cmd)
    );

    stbs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_data        (in_data),
        .cmd            (cmd),
        .status         (status),
        .out_data       (out_data)
    );

endmodule

FILE: tb/sv/sorted_table_binary_search_tb.sv
// Testbench for sorted_table_binary_search: table loads and searches checked against a predictor.
module sorted_table_binary_search_tb;
    import stbs_pkg::*;

    // Predicts each search answer from a private copy of the key table and count
    class search_scoreboard;
        logic signed [KEY_W-1:0] key_mirror [TABLE_DEPTH];
        int                      active_entries;
        out_beat_t               expected_answers [$];
        int                      errors;

        function new();
            active_entries = 0;
            errors         = 0;
        endfunction

        function void set_count(input logic [COUNT_W-1:0] value);
            active_entries = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
        endfunction

        // Accepted input beat: a load updates the mirror, a search queues its answer
        function void note_beat(input in_beat_t b);
            int        lo;
            int        hi;
            int        mid;
            out_beat_t ans;
            if (b.command == CMD_LOAD)
            begin
                key_mirror[b.entry_position] = b.key_value;
                return;
            end
            ans = '0;
            lo  = 0;
            hi  = active_entries - 1;
            while (lo <= hi && !ans.found)
            begin
                mid = (lo + hi) / 2;
                if (key_mirror[mid] == b.key_value)
                begin
                    ans.found          = 1'b1;
                    ans.match_position = POS_W'(mid);
                end
                else if ($signed(key_mirror[mid]) < $signed(b.key_value))
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            expected_answers.insert(expected_answers.size(), ans);
        endfunction

        // Accepted output beat: compare with the oldest queued answer
        function void check_answer(input out_beat_t got);
            out_beat_t exp;
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected answer found=%0b pos=%0d", $time,
                         got.found, got.match_position);
                errors++;
                return;
            end
            exp = expected_answers.pop_front();
            if (got.found !== exp.found)
            begin
                $display("%0t: found mismatch: expected %0b, actual %0b", $time,
                         exp.found, got.found);
                errors++;
            end
            if (got.match_position !== exp.match_position)
            begin
                $display("%0t: match_position mismatch: expected %0d, actual %0d", $time,
                         exp.match_position, got.match_position);
                errors++;
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [COUNT_W-1:0]   cfg_write_data;
    logic                 in_valid;
    logic                 in_stall;
    in_beat_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_beat_t            out_data;

    search_scoreboard sb = new();

    // Idle control shared between stimulus and the output side
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;
    int   rx_hold = 0;

    int directed_keys [16] = '{32'sh8000_0000, 32'sh8000_0001, -1000, -5, -5, -5, -1, 0,
                               0, 1, 7, 7, 100, 32'sh4000_0000, 32'sh7FFF_FFFE,
                               32'sh7FFF_FFFF};
    // Negative entries pick a random count at run time
    int count_plan [12] = '{128, 1, 2, 255, 3, 64, 127, 0, 129, -1, 5, -1};

    sorted_table_binary_search DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one beat and hold it until accepted
    task automatic send_beat(input in_beat_t b);
        int gap;
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        sb.note_beat(b);
    endtask

    task automatic load_key(input logic [POS_W-1:0] pos, input logic signed [KEY_W-1:0] key);
        in_beat_t b;
        b.command        = CMD_LOAD;
        b.entry_position = pos;
        b.key_value      = key;
        send_beat(b);
    endtask

    task automatic search_key(input logic signed [KEY_W-1:0] key);
        in_beat_t b;
        b.command        = CMD_SEARCH;
        b.entry_position = POS_W'($urandom);
        b.key_value      = key;
        send_beat(b);
    endtask

    // Stop offering, wait for every queued answer, then let the block settle
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.set_count(value);
    endtask

    // Fill positions 0..n-1 with a non-decreasing random sequence
    task automatic load_sorted(input int n);
        longint maxstep;
        longint room;
        longint cur;
        int     i;
        case ($urandom_range(0, 2))
            0:       maxstep = 2;
            1:       maxstep = 1000;
            default: maxstep = 64'hFFFF_FFFF / n;
        endcase
        room = 64'hFFFF_FFFF - maxstep * n;
        cur  = (longint'($urandom) % (room + 1)) - 64'sd2147483648;
        for (i = 0; i < n; i++)
        begin
            load_key(POS_W'(i), cur[KEY_W-1:0]);
            cur += $urandom_range(0, 32'(maxstep));
        end
    endtask

    // Output side: check accepted beats, stall in random runs or on request
    initial
    begin
        int stall_left;
        int run_left;
        out_stall  = 1'b0;
        stall_left = 0;
        run_left   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_answer(out_data);
            if (rx_hold > 0)
            begin
                stall_left = rx_hold;
                rx_hold    = 0;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
                else
                begin
                    stall_left = rx_calm ? 0 : idle_len();
                    run_left   = $urandom_range(0, 5);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int                      p;
        int                      i;
        int                      r;
        int                      cnt;
        int                      eff;
        int                      pick;
        logic signed [KEY_W-1:0] probe_key;

        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty count, extreme keys, duplicates, last position
        search_key(32'sh8000_0000);
        search_key(32'sh7FFF_FFFF);
        for (i = 0; i < 16; i++)
            load_key(POS_W'(i), directed_keys[i]);
        load_key(POS_W'(TABLE_DEPTH - 1), 32'sh5A5A_A5A5);
        drain(16);
        write_count(8'd16);
        search_key(32'sh8000_0000);
        search_key(32'sh7FFF_FFFF);
        search_key(-5);
        search_key(7);
        search_key(2);

        // Random phases, one count setting each
        for (p = 0; p < 12; p++)
        begin
            drain(16);
            cnt = (count_plan[p] < 0) ? $urandom_range(1, TABLE_DEPTH) : count_plan[p];
            write_count(COUNT_W'(cnt));
            eff     = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (eff > 0 && (p == 0 || $urandom_range(0, 3) == 0))
                load_sorted(eff);
            // Long output hold-off while input keeps coming
            if (p == 3)
            begin
                tx_calm = 1'b1;
                rx_hold = 300;
            end
            for (i = 0; i < 20; i++)
            begin
                if (i == 10 && (p == 2 || $urandom_range(0, 3) == 0))
                    drain(0);
                r = $urandom_range(0, 99);
                if (eff > 0)
                    pick = $urandom_range(0, eff - 1);
                if (r < 15)
                    load_key(POS_W'($urandom), $urandom);
                else if (r < 55 && eff > 0)
                    search_key(sb.key_mirror[pick]);
                else if (r < 75 && eff > 0)
                begin
                    probe_key = sb.key_mirror[pick] + ($urandom_range(0, 1) ? 1 : -1);
                    search_key(probe_key);
                end
                else
                    search_key($urandom);
            end
        end

        drain(24);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: sorted_table_binary_search.f
rtl/stbs_pkg.sv
rtl/stbs_datapath.sv
rtl/stbs_ctrl.sv
rtl/sorted_table_binary_search.sv
tb/sv/sorted_table_binary_search_tb.sv
